// File: hdl/lphi_pkg.sv
// Shared types and constants for the linear probing hash insert block.
package lphi_pkg;

    // Fixed field widths of the words on the ports.
    localparam int SIZE_W   = 7;
    localparam int CHAR_W   = 8;
    localparam int SLOT_W   = 6;
    localparam int STATUS_W = 2;

    // Largest value of one key byte, used to size the hash sum.
    localparam int CHAR_MAX = 255;

    // Table size after reset.
    localparam logic [SIZE_W-1:0] SIZE_RESET = 7'd10;

    // Command codes of an input word.
    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_READ   = 1'b1;

    // Status codes of a result word.
    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_LONG  = 2'd2,
        ST_EMPTY = 2'd3
    } t_status;

endpackage

// File: hdl/lphi_if.sv
// Valid/ready channel interfaces for the input and result words.
interface lphi_in_if import lphi_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              cmd;
    logic [CHAR_W-1:0] key_char;
    logic              key_last;
    logic [SLOT_W-1:0] read_slot;

    modport source (output valid, cmd, key_char, key_last, read_slot, input ready);
    modport sink   (input valid, cmd, key_char, key_last, read_slot, output ready);
endinterface

interface lphi_out_if import lphi_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [SLOT_W-1:0]   slot;
    logic [STATUS_W-1:0] status;
    logic [CHAR_W-1:0]   out_char;
    logic                out_last;

    modport source (output valid, slot, status, out_char, out_last, input ready);
    modport sink   (input valid, slot, status, out_char, out_last, output ready);
endinterface

// File: hdl/lphi_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module lphi_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: hdl/lphi_mod.sv
// Iterative remainder unit: one restoring subtract step per cycle.
module lphi_mod import lphi_pkg::*; #(
    parameter int DIV_W = 10
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [DIV_W-1:0]  i_dividend,
    input  logic [SIZE_W-1:0] i_divisor,
    output logic              o_done,
    output logic [SIZE_W-1:0] o_rem
);

    localparam int KW  = $clog2(DIV_W);
    localparam int EXW = DIV_W + SIZE_W;

    logic [DIV_W-1:0] r_rem;
    logic [KW-1:0]    r_k;
    logic             r_busy;
    logic             r_done;
    logic [EXW-1:0]   shifted;
    logic [EXW-1:0]   diff;
    logic             ge;

    // The divisor is shifted up to the current bit and taken off where it fits.
    always_comb begin
        shifted = EXW'(i_divisor) << r_k;
        ge      = (EXW'(r_rem) >= shifted);
        diff    = EXW'(r_rem) - shifted;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && (r_k == '0)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_dividend;
            r_k   <= KW'(DIV_W - 1);
        end else if (r_busy) begin
            if (ge) begin
                r_rem <= DIV_W'(diff);
            end
            r_k <= r_k - KW'(1);
        end
    end

    assign o_done = r_done;
    assign o_rem  = SIZE_W'(r_rem);

endmodule

// File: hdl/linear_probe_hash_insert_core.sv
// Top level of the linear probing hash insert block.
// Keys arrive one byte per input word, the final byte marked by key_last. On the final byte the
// home slot is (first byte + last byte + length) modulo the table size. An iterative remainder
// unit works this out one bit of the hash sum at a time and then reports it. The slot metadata
// RAM (valid bit and length) is then probed one slot per cycle, wrapping at the table size. The
// key is copied from the key buffer RAM into the slot's byte area at one byte per cycle. A read
// command first reads the slot's metadata, then gives one empty-status word or streams the
// slot's stored bytes at one result word per cycle while the output register is free. After
// reset the block clears the metadata RAM one slot per cycle and accepts no word until that
// pass is done; the table size register may be written throughout. Results leave through an
// output register, so the block finishes its work while a result waits to be taken. A full
// table or an overlong key gives one result word carrying the matching status, and nothing is
// stored.
module linear_probe_hash_insert_core import lphi_pkg::*; #(
    parameter int MAX_SLOTS = 64,
    parameter int KEY_MAX   = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [SIZE_W-1:0] i_cfg_wdata,
    lphi_in_if.sink           i_in,
    lphi_out_if.source        o_res
);

    // Widths that follow from the parameters.
    localparam int IW   = $clog2(MAX_SLOTS);
    localparam int LW   = $clog2(KEY_MAX + 1);
    localparam int KAW  = (KEY_MAX > 1) ? $clog2(KEY_MAX) : 1;
    localparam int BD   = MAX_SLOTS * KEY_MAX;
    localparam int BAW  = $clog2(BD);
    localparam int HW   = $clog2(2 * CHAR_MAX + KEY_MAX + 1);
    localparam int MW   = 1 + LW;
    localparam int CMPW = ((IW + 1) > SIZE_W) ? (IW + 1) : SIZE_W;

    typedef enum logic [7:0] {
        S_CLEAR   = 8'b0000_0001,
        S_IDLE    = 8'b0000_0010,
        S_MOD     = 8'b0000_0100,
        S_PROBE   = 8'b0000_1000,
        S_COPY    = 8'b0001_0000,
        S_RD_CHK  = 8'b0010_0000,
        S_RD_BYTE = 8'b0100_0000,
        S_EMIT    = 8'b1000_0000
    } t_state;

    t_state              r_state, n_state;
    logic [SIZE_W-1:0]   r_ts;
    logic [LW-1:0]       r_klen, n_klen;
    logic                r_too_long, n_too_long;
    logic [CHAR_W-1:0]   r_first, n_first;
    logic [IW-1:0]       r_probe, n_probe;
    logic [SIZE_W-1:0]   r_count, n_count;
    logic [KAW-1:0]      r_kidx, n_kidx;
    logic [BAW-1:0]      r_baddr, n_baddr;
    logic [LW-1:0]       r_len, n_len;
    logic [SLOT_W-1:0]   r_rslot, n_rslot;
    logic [IW-1:0]       r_clr, n_clr;
    t_status             r_est, n_est;
    logic [SLOT_W-1:0]   r_eslot, n_eslot;

    logic                r_out_valid;
    logic [SLOT_W-1:0]   r_out_slot;
    t_status             r_out_status;
    logic [CHAR_W-1:0]   r_out_char;
    logic                r_out_last;

    logic                emit_en;
    logic [SLOT_W-1:0]   emit_slot;
    t_status             emit_status;
    logic [CHAR_W-1:0]   emit_char;
    logic                emit_last;
    logic                out_free;
    logic                in_acc;

    logic [SIZE_W-1:0]   eff;
    logic [HW-1:0]       hsum;
    logic [CHAR_W-1:0]   first_eff;
    logic                mod_start;
    logic                mod_done;
    logic [SIZE_W-1:0]   mod_rem;

    logic                kb_we;
    logic [CHAR_W-1:0]   kb_rdata;
    logic                meta_we;
    logic [IW-1:0]       meta_waddr;
    logic [MW-1:0]       meta_wdata;
    logic [MW-1:0]       meta_rdata;
    logic                meta_valid;
    logic [LW-1:0]       meta_len;
    logic                byte_we;
    logic [CHAR_W-1:0]   byte_rdata;
    logic [BAW-1:0]      slot_base;
    logic                rd_last;
    logic                cp_last;

    // Table size register; it may be written at any time, also during the clearing pass.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ts <= SIZE_RESET;
        end else if (i_cfg_we) begin
            r_ts <= i_cfg_wdata;
        end
    end

    // A size of zero acts as one, and a size beyond the table acts as the whole table.
    always_comb begin
        if (r_ts == '0) begin
            eff = SIZE_W'(1);
        end else if (CMPW'(r_ts) > CMPW'(MAX_SLOTS)) begin
            eff = SIZE_W'(MAX_SLOTS);
        end else begin
            eff = r_ts;
        end
    end

    assign in_acc    = i_in.valid && i_in.ready;
    assign i_in.ready = (r_state == S_IDLE);
    assign out_free  = !r_out_valid || o_res.ready;

    // Hash sum for a key that completes with the byte now on the input.
    assign first_eff = (r_klen == '0) ? i_in.key_char : r_first;
    assign hsum      = HW'(first_eff) + HW'(i_in.key_char) + HW'(r_klen) + HW'(1);

    assign meta_valid = meta_rdata[LW];
    assign meta_len   = meta_rdata[LW-1:0];
    assign slot_base  = BAW'(BAW'(r_probe) * BAW'(KEY_MAX));
    assign rd_last    = ((LW'(r_kidx) + LW'(1)) == r_len);
    assign cp_last    = ((LW'(r_kidx) + LW'(1)) == r_klen);

    always_comb begin
        n_state     = r_state;
        n_klen      = r_klen;
        n_too_long  = r_too_long;
        n_first     = r_first;
        n_probe     = r_probe;
        n_count     = r_count;
        n_kidx      = r_kidx;
        n_baddr     = r_baddr;
        n_len       = r_len;
        n_rslot     = r_rslot;
        n_clr       = r_clr;
        n_est       = r_est;
        n_eslot     = r_eslot;
        emit_en     = 1'b0;
        emit_slot   = r_eslot;
        emit_status = r_est;
        emit_char   = '0;
        emit_last   = 1'b1;
        kb_we       = 1'b0;
        meta_we     = 1'b0;
        meta_waddr  = r_probe;
        meta_wdata  = '0;
        byte_we     = 1'b0;
        mod_start   = 1'b0;

        case (r_state)
            S_CLEAR: begin
                // Clearing pass: every slot is marked empty once after reset.
                meta_we    = 1'b1;
                meta_waddr = r_clr;
                n_clr      = r_clr + IW'(1);
                if (r_clr == IW'(MAX_SLOTS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_acc) begin
                    if (i_in.cmd == CMD_READ) begin
                        n_rslot = i_in.read_slot;
                        if (CMPW'(i_in.read_slot) < CMPW'(MAX_SLOTS)) begin
                            n_probe = IW'(i_in.read_slot);
                            n_state = S_RD_CHK;
                        end else begin
                            n_est   = ST_EMPTY;
                            n_eslot = i_in.read_slot;
                            n_state = S_EMIT;
                        end
                    end else begin
                        if (r_klen < LW'(KEY_MAX)) begin
                            kb_we  = 1'b1;
                            n_klen = r_klen + LW'(1);
                            if (r_klen == '0) begin
                                n_first = i_in.key_char;
                            end
                        end else begin
                            n_too_long = 1'b1;
                        end
                        if (i_in.key_last) begin
                            if (r_too_long || (r_klen == LW'(KEY_MAX))) begin
                                // Overlong key: report it and drop the pending key.
                                n_est      = ST_LONG;
                                n_eslot    = '0;
                                n_klen     = '0;
                                n_too_long = 1'b0;
                                n_state    = S_EMIT;
                            end else begin
                                mod_start = 1'b1;
                                n_state   = S_MOD;
                            end
                        end
                    end
                end
            end
            S_MOD: begin
                if (mod_done) begin
                    n_probe = IW'(mod_rem);
                    n_count = '0;
                    n_state = S_PROBE;
                end
            end
            S_PROBE: begin
                // The metadata of r_probe is on the RAM output in this cycle.
                if (!meta_valid) begin
                    n_kidx  = '0;
                    n_baddr = slot_base;
                    n_state = S_COPY;
                end else if ((r_count + SIZE_W'(1)) == eff) begin
                    // Every slot within the size has been visited.
                    n_est      = ST_FULL;
                    n_eslot    = '0;
                    n_klen     = '0;
                    n_too_long = 1'b0;
                    n_state    = S_EMIT;
                end else begin
                    n_count = r_count + SIZE_W'(1);
                    if ((CMPW'(r_probe) + CMPW'(1)) == CMPW'(eff)) begin
                        n_probe = '0;
                    end else begin
                        n_probe = r_probe + IW'(1);
                    end
                end
            end
            S_COPY: begin
                // One key byte moves from the key buffer to the slot each cycle.
                byte_we = 1'b1;
                if (cp_last) begin
                    meta_we    = 1'b1;
                    meta_waddr = r_probe;
                    meta_wdata = {1'b1, r_klen};
                    n_est      = ST_OK;
                    n_eslot    = SLOT_W'(r_probe);
                    n_klen     = '0;
                    n_state    = S_EMIT;
                end else begin
                    n_kidx  = r_kidx + KAW'(1);
                    n_baddr = r_baddr + BAW'(1);
                end
            end
            S_RD_CHK: begin
                if (!meta_valid || (meta_len == '0) || (meta_len > LW'(KEY_MAX))) begin
                    n_est   = ST_EMPTY;
                    n_eslot = r_rslot;
                    n_state = S_EMIT;
                end else begin
                    n_len   = meta_len;
                    n_kidx  = '0;
                    n_baddr = slot_base;
                    n_state = S_RD_BYTE;
                end
            end
            S_RD_BYTE: begin
                // The read address holds while the output is stalled, so the byte stays.
                if (out_free) begin
                    emit_en     = 1'b1;
                    emit_slot   = r_rslot;
                    emit_status = ST_OK;
                    emit_char   = byte_rdata;
                    emit_last   = rd_last;
                    if (rd_last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_kidx  = r_kidx + KAW'(1);
                        n_baddr = r_baddr + BAW'(1);
                    end
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    emit_en = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_clr      <= '0;
            r_klen     <= '0;
            r_too_long <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_clr      <= n_clr;
            r_klen     <= n_klen;
            r_too_long <= n_too_long;
        end
    end

    always_ff @(posedge i_clk) begin
        r_first <= n_first;
        r_probe <= n_probe;
        r_count <= n_count;
        r_kidx  <= n_kidx;
        r_baddr <= n_baddr;
        r_len   <= n_len;
        r_rslot <= n_rslot;
        r_est   <= n_est;
        r_eslot <= n_eslot;
    end

    // Output register: a finished word waits here while the block moves on.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit_en) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit_en) begin
            r_out_slot   <= emit_slot;
            r_out_status <= emit_status;
            r_out_char   <= emit_char;
            r_out_last   <= emit_last;
        end
    end

    assign o_res.valid    = r_out_valid;
    assign o_res.slot     = r_out_slot;
    assign o_res.status   = r_out_status;
    assign o_res.out_char = r_out_char;
    assign o_res.out_last = r_out_last;

    lphi_mod #(
        .DIV_W (HW)
    ) u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (mod_start),
        .i_dividend (hsum),
        .i_divisor  (eff),
        .o_done     (mod_done),
        .o_rem      (mod_rem)
    );

    // Pending key bytes.
    lphi_ram #(
        .WIDTH (CHAR_W),
        .DEPTH (KEY_MAX)
    ) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (kb_we),
        .i_waddr (r_klen[KAW-1:0]),
        .i_wdata (i_in.key_char),
        .i_raddr (n_kidx),
        .o_rdata (kb_rdata)
    );

    // Valid bit and key length of each slot.
    lphi_ram #(
        .WIDTH (MW),
        .DEPTH (MAX_SLOTS)
    ) u_meta_ram (
        .i_clk   (i_clk),
        .i_we    (meta_we),
        .i_waddr (meta_waddr),
        .i_wdata (meta_wdata),
        .i_raddr (n_probe),
        .o_rdata (meta_rdata)
    );

    // Stored key bytes, KEY_MAX entries per slot.
    lphi_ram #(
        .WIDTH (CHAR_W),
        .DEPTH (BD)
    ) u_byte_ram (
        .i_clk   (i_clk),
        .i_we    (byte_we),
        .i_waddr (r_baddr),
        .i_wdata (kb_rdata),
        .i_raddr (n_baddr),
        .o_rdata (byte_rdata)
    );

endmodule

// File: bench/tb_linear_probe_hash_insert_core.sv
// Self-checking testbench for the linear probing hash insert block, with its own table predictor.
`timescale 1ns / 1ps

module tb_linear_probe_hash_insert_core import lphi_pkg::*; ();

    // Sizes of the block under test; the predictor uses the same ones.
    localparam int N_SLOTS   = 64;
    localparam int KEY_BYTES = 16;

    // An insert walks the remainder unit, up to every slot and then every byte of
    // the key, while no word moves on either side. This is the settling pause before
    // a register write and at the end of the run.
    localparam int SETTLE_CYCLES = 128;

    // Longest stretch with no word moving on either side before the run is declared
    // hung. The slowest correct stretch is the long receiver hold-off plus an insert
    // plus a long sender gap.
    localparam int QUIET_LIMIT = 2000;

    // Length of the deliberate receiver hold-off in the back-pressure test.
    localparam int HOLD_OFF_CYCLES = 300;

    // One input word as the sender sees it.
    typedef struct packed {
        logic              cmd;
        logic [CHAR_W-1:0] key_char;
        logic              key_last;
        logic [SLOT_W-1:0] read_slot;
    } t_key_word;

    // One result word as the block should produce it.
    typedef struct packed {
        logic [SLOT_W-1:0] slot;
        t_status           status;
        logic [CHAR_W-1:0] out_char;
        logic              out_last;
    } t_slot_report;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_cfg_we;
    logic [SIZE_W-1:0] i_cfg_wdata;

    lphi_in_if  in_ch ();
    lphi_out_if res_ch ();

    linear_probe_hash_insert_core #(
        .MAX_SLOTS(N_SLOTS),
        .KEY_MAX  (KEY_BYTES)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .i_in       (in_ch),
        .o_res      (res_ch)
    );

    // Predicted contents of the hash table. The table is cleared at reset; the
    // byte and length stores are only ever read inside a valid slot's key.
    logic              tbl_used  [N_SLOTS];
    logic [4:0]        tbl_len   [N_SLOTS];
    logic [CHAR_W-1:0] tbl_bytes [N_SLOTS][KEY_BYTES];

    // The key being assembled, and whether it has run past the longest allowed key.
    logic [CHAR_W-1:0] key_buf [KEY_BYTES];
    int unsigned       key_len;
    bit                key_overflow;

    // Predicted table size register, exactly as written (out-of-range values kept).
    logic [SIZE_W-1:0] size_reg;

    // Result words still owed by the block, oldest first.
    t_slot_report slot_reports [$];

    // Idling controls shared by the stimulus and the result sink.
    int unsigned tx_gap_pct;
    int unsigned rx_stall_pct;
    int unsigned hold_cycles;

    // Run bookkeeping.
    int unsigned fail_count;
    int unsigned words_sent;
    int unsigned quiet_cycles = 0;
    int unsigned n_stored, n_full, n_long, n_empty, n_read_bytes;

    // Free-running clock with a 10 ns period.
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Idle gap length: one draw in ten comes from the long range, the rest from the short one.
    function automatic int unsigned pick_gap();
        if ($urandom_range(0, 9) == 0) return $urandom_range(12, 40);
        return $urandom_range(1, 3);
    endfunction

    // Key byte word; the unused read_slot field is randomised so that its bits toggle.
    function automatic t_key_word key_byte(input logic [CHAR_W-1:0] ch, input logic fin);
        t_key_word w;
        w.cmd       = CMD_INSERT;
        w.key_char  = ch;
        w.key_last  = fin;
        w.read_slot = SLOT_W'($urandom_range(0, N_SLOTS - 1));
        return w;
    endfunction

    // Read word; the key fields are ignored by the block, so they carry noise.
    function automatic t_key_word read_cmd(input logic [SLOT_W-1:0] slot_no);
        t_key_word w;
        w.cmd       = CMD_READ;
        w.key_char  = CHAR_W'($urandom_range(0, 255));
        w.key_last  = 1'($urandom_range(0, 1));
        w.read_slot = slot_no;
        return w;
    endfunction

    // Chooses a slot to read: usually one that holds a key, so that whole keys stream
    // back, and otherwise any slot at all, which will often be empty.
    function automatic logic [SLOT_W-1:0] pick_read_slot();
        int unsigned start;
        int unsigned n;
        start = $urandom_range(0, N_SLOTS - 1);
        if ($urandom_range(0, 3) != 0) begin
            for (n = 0; n < N_SLOTS; n++) begin
                if (tbl_used[(start + n) % N_SLOTS]) return SLOT_W'((start + n) % N_SLOTS);
            end
        end
        return SLOT_W'(start);
    endfunction

    function automatic void queue_report(input logic [SLOT_W-1:0] slot_no, input t_status st,
                                         input logic [CHAR_W-1:0] ch, input logic fin);
        t_slot_report r;
        r.slot     = slot_no;
        r.status   = st;
        r.out_char = ch;
        r.out_last = fin;
        slot_reports.push_back(r);
    endfunction

    // Applies one accepted word to the predicted table and queues the result words
    // it gives rise to. A non-final key byte gives none; a read gives one per stored
    // byte, or a single empty report. Stored keys and streamed bytes are tallied
    // here, since a stored key and a read byte share the ok status on the way back.
    function automatic void hash_table_apply(input t_key_word w);
        int unsigned span;
        int unsigned home;
        int unsigned n;
        int unsigned i;
        bit          found;
        if (w.cmd == CMD_READ) begin
            // A read never disturbs a key that is half assembled.
            if (!tbl_used[w.read_slot] || tbl_len[w.read_slot] == 0) begin
                queue_report(w.read_slot, ST_EMPTY, '0, 1'b1);
            end else begin
                for (i = 0; i < tbl_len[w.read_slot]; i++)
                    queue_report(w.read_slot, ST_OK, tbl_bytes[w.read_slot][i],
                                 i + 1 == tbl_len[w.read_slot]);
                n_read_bytes += tbl_len[w.read_slot];
            end
            return;
        end

        // Bytes beyond the longest key are dropped, and the key is marked as too long.
        if (key_len < KEY_BYTES) begin
            key_buf[key_len] = w.key_char;
            key_len++;
        end else begin
            key_overflow = 1'b1;
        end
        if (!w.key_last) return;

        if (key_overflow) begin
            queue_report('0, ST_LONG, '0, 1'b1);
        end else begin
            // A size of zero behaves as one, and anything past the slot count as the
            // slot count itself.
            span = (size_reg == 0) ? 1 : (size_reg > N_SLOTS) ? N_SLOTS : size_reg;
            home = (int'(key_buf[0]) + int'(key_buf[key_len - 1]) + key_len) % span;
            found = 1'b0;
            for (n = 0; n < span; n++) begin
                if (!tbl_used[home]) begin
                    found = 1'b1;
                    break;
                end
                home = (home + 1) % span;
            end
            if (!found) begin
                queue_report('0, ST_FULL, '0, 1'b1);
            end else begin
                for (i = 0; i < key_len; i++) tbl_bytes[home][i] = key_buf[i];
                tbl_len[home]  = 5'(key_len);
                tbl_used[home] = 1'b1;
                n_stored++;
                queue_report(SLOT_W'(home), ST_OK, '0, 1'b1);
            end
        end
        key_len      = 0;
        key_overflow = 1'b0;
    endfunction

    // Offers one word, possibly after a random gap, holds it until the block takes
    // it, and then updates the prediction. Valid is left high so that the next word
    // can follow back to back; anything that waits lowers it first.
    task automatic send_word(input t_key_word w);
        int unsigned gap;
        @(negedge i_clk);
        gap = (tx_gap_pct != 0 && $urandom_range(1, 100) <= tx_gap_pct) ? pick_gap() : 0;
        if (gap != 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.cmd       <= w.cmd;
        in_ch.key_char  <= w.key_char;
        in_ch.key_last  <= w.key_last;
        in_ch.read_slot <= w.read_slot;
        do @(posedge i_clk); while (!in_ch.ready);
        hash_table_apply(w);
        words_sent++;
    endtask

    // Streams a key of random bytes. Now and then a read is slipped in between two
    // of its bytes, which must leave the key being assembled untouched.
    task automatic send_key(input int unsigned n_bytes);
        int unsigned i;
        for (i = 1; i <= n_bytes; i++) begin
            if (i > 1 && $urandom_range(0, 19) == 0) send_word(read_cmd(pick_read_slot()));
            send_word(key_byte(CHAR_W'($urandom_range(0, 255)), i == n_bytes));
        end
    endtask

    // Stops offering words and waits until every owed result word has arrived, then
    // lets the block settle.
    task automatic drain_results();
        @(negedge i_clk);
        in_ch.valid <= 1'b0;
        while (slot_reports.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Writes the table size register once the block is idle.
    task automatic set_table_size(input logic [SIZE_W-1:0] value);
        drain_results();
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        size_reg = value;
    endtask

    // Hand-picked keys at the reset size of ten: the smallest and largest byte, a
    // collision that probes forward, one that wraps round to slot 0, reads of full
    // and empty slots, a read in the middle of a key, and a key that is too long.
    task automatic test_directed_keys();
        send_word(key_byte(8'h00, 1'b1));
        send_word(key_byte(8'hFF, 1'b1));
        send_word(key_byte(8'h04, 1'b1));
        send_word(key_byte(8'h04, 1'b1));
        send_word(read_cmd(6'd0));
        send_word(read_cmd(6'd63));
        send_word(read_cmd(6'd1));
        send_word(key_byte(8'hA5, 1'b0));
        send_word(read_cmd(6'd9));
        send_word(key_byte(8'h5A, 1'b1));
        send_key(KEY_BYTES + 1);
    endtask

    // Sizes of zero and one squeeze the table down to slot 0, which is already
    // taken, so inserts report a full table; a slot beyond the size is still read.
    task automatic test_table_full();
        set_table_size(7'd0);
        send_word(key_byte(8'h00, 1'b1));
        send_word(read_cmd(6'd9));
        set_table_size(7'd1);
        send_key(3);
        send_word(read_cmd(6'd2));
    endtask

    // Four phases of mixed keys and reads, each at its own table size and with its
    // own idling pattern: none, sender gaps, receiver stalls, then both together.
    task automatic test_random_traffic();
        logic [SIZE_W-1:0] spans [4];
        int unsigned       phase;
        int unsigned       quota;
        int unsigned       pick;
        int unsigned       len;
        spans[0] = 7'd20;
        spans[1] = SIZE_W'($urandom_range(2, N_SLOTS - 1));
        spans[2] = 7'd127;
        spans[3] = 7'd64;
        for (phase = 0; phase < 4; phase++) begin
            set_table_size(spans[phase]);
            tx_gap_pct   = phase[0] ? 30 : 0;
            rx_stall_pct = phase[1] ? 30 : 0;
            quota = words_sent + 40;
            while (words_sent < quota) begin
                pick = $urandom_range(0, 99);
                if (pick < 30) begin
                    send_word(read_cmd(pick_read_slot()));
                end else begin
                    // Mostly short keys, some longer, a few at the limit and past it.
                    pick = $urandom_range(0, 99);
                    if (pick < 60)      len = $urandom_range(1, 4);
                    else if (pick < 85) len = $urandom_range(5, KEY_BYTES - 1);
                    else if (pick < 92) len = KEY_BYTES;
                    else                len = $urandom_range(KEY_BYTES + 1, KEY_BYTES + 4);
                    send_key(len);
                end
            end
        end
        tx_gap_pct   = 0;
        rx_stall_pct = 0;
    endtask

    // The receiver holds off for a long stretch while reads keep being offered, so
    // the output register fills and the block has to stall its input. The sender
    // then waits for every owed word and sends keys amid gaps and stalls.
    task automatic test_backpressure();
        int unsigned n;
        hold_cycles = HOLD_OFF_CYCLES;
        for (n = 0; n < 12; n++) send_word(read_cmd(pick_read_slot()));
        drain_results();
        rx_stall_pct = 20;
        tx_gap_pct   = 20;
        for (n = 0; n < 6; n++) send_key($urandom_range(1, 6));
    endtask

    // Result sink: ready drops for random stretches when stalls are enabled, and
    // for the full hold-off when a test asks for one. Ready changes only on the
    // falling edge.
    initial begin : result_sink
        int unsigned stall;
        res_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            stall = 0;
            if (hold_cycles != 0) begin
                stall       = hold_cycles;
                hold_cycles = 0;
            end else if (rx_stall_pct != 0 && $urandom_range(1, 100) <= rx_stall_pct) begin
                stall = pick_gap();
            end
            if (stall != 0) begin
                res_ch.ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            res_ch.ready <= 1'b1;
        end
    end

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endfunction

    // Every result word taken is compared with the oldest owed word, field by field.
    always @(posedge i_clk) begin : result_check
        t_slot_report want;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            if (slot_reports.size() == 0) begin
                $error("result word with nothing owed: slot %0d status %0d char %0d last %0d",
                       res_ch.slot, res_ch.status, res_ch.out_char, res_ch.out_last);
                fail_count++;
            end else begin
                want = slot_reports.pop_front();
                check_field("slot", want.slot, res_ch.slot);
                check_field("status", want.status, res_ch.status);
                check_field("out_char", want.out_char, res_ch.out_char);
                check_field("out_last", want.out_last, res_ch.out_last);
                if (want.status == ST_FULL)  n_full++;
                if (want.status == ST_LONG)  n_long++;
                if (want.status == ST_EMPTY) n_empty++;
            end
        end
    end

    // Watchdog: counts cycles in which no word moves on either channel.
    always @(posedge i_clk) begin : hang_watch
        if ((in_ch.valid && in_ch.ready) || (res_ch.valid && res_ch.ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("hang: no word moved for %0d cycles", QUIET_LIMIT);
                $display("tb_linear_probe_hash_insert_core: done, errors");
                $finish;
            end
        end
    end

    initial begin : stimulus
        in_ch.valid     = 1'b0;
        in_ch.cmd       = CMD_INSERT;
        in_ch.key_char  = '0;
        in_ch.key_last  = 1'b0;
        in_ch.read_slot = '0;
        i_cfg_we        = 1'b0;
        i_cfg_wdata     = SIZE_RESET;
        i_rst_n         = 1'b0;

        // The predicted table starts empty, as the block's clearing pass leaves it.
        foreach (tbl_used[s]) tbl_used[s] = 1'b0;
        key_len      = 0;
        key_overflow = 1'b0;
        size_reg     = SIZE_RESET;
        tx_gap_pct   = 0;
        rx_stall_pct = 0;
        hold_cycles  = 0;
        fail_count   = 0;
        words_sent   = 0;
        n_stored     = 0;
        n_full       = 0;
        n_long       = 0;
        n_empty      = 0;
        n_read_bytes = 0;

        // Synchronous reset held low over rising edges, released on a falling one.
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_keys();
        test_table_full();
        test_random_traffic();
        test_backpressure();

        drain_results();
        $display("Sent %0d input words; %0d keys stored, %0d full-table and %0d overlong reports,",
                 words_sent, n_stored, n_full, n_long);
        $display("%0d key bytes read back and %0d empty-slot reads, table sizes 0 to 127.",
                 n_read_bytes, n_empty);
        if (fail_count == 0) begin
            $display("tb_linear_probe_hash_insert_core: done, clean");
        end else begin
            $display("tb_linear_probe_hash_insert_core: done, errors");
        end
        $finish;
    end

endmodule
